[rtl/dpcr_pkg.sv]
// ----------------------------------------------------------------------------
// dpcr_pkg: shared types and constants for the debounced press reporter
// Controller commands, datapath status, register indexes and fixed text.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcr_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

  localparam logic [2:0] FIXED_LAST = 3'd4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREFIX,
    ST_FIXED,
    ST_DIGIT,
    ST_NL,
    ST_CR
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC,
    IDX_LEAD
  } idx_op_t;

  typedef enum logic [2:0] {
    SEL_PREFIX,
    SEL_FIXED,
    SEL_DIGIT,
    SEL_NL,
    SEL_CR
  } sel_t;

  typedef struct packed {
    logic    take_tick;
    logic    shift;
    idx_op_t idx_op;
    sel_t    sel;
  } cmd_t;

  typedef struct packed {
    logic press_evt;
    logic conv_last;
    logic len_zero;
    logic prefix_last;
    logic fixed_last;
    logic idx_zero;
  } status_t;

  function automatic logic [7:0] fixed_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CHAR_COLON;
      3'd1:    c = CHAR_B;
      3'd2:    c = CHAR_T;
      3'd3:    c = CHAR_N;
      default: c = CHAR_COLON;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/dpcr_ctrl.sv]
// ----------------------------------------------------------------------------
// dpcr_ctrl: message sequencer
// Takes ticks while idle, runs the decimal conversion, then steps the bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  end_of_message,
  output dpcr_pkg::cmd_t        cmd,
  input  wire dpcr_pkg::status_t status
);

  dpcr_pkg::state_t state, state_next;
  logic fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    end_of_message = 1'b0;
    cmd.take_tick  = 1'b0;
    cmd.shift      = 1'b0;
    cmd.idx_op     = dpcr_pkg::IDX_HOLD;
    cmd.sel        = dpcr_pkg::SEL_PREFIX;
    fire           = 1'b0;
    case (state)
      dpcr_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_tick = in_valid;
        cmd.idx_op    = dpcr_pkg::IDX_CLEAR;
        if (status.press_evt) begin
          state_next = dpcr_pkg::ST_CONV;
        end
      end
      dpcr_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.conv_last) begin
          state_next = status.len_zero ? dpcr_pkg::ST_FIXED : dpcr_pkg::ST_PREFIX;
        end
      end
      dpcr_pkg::ST_PREFIX: begin
        out_valid = 1'b1;
        cmd.sel   = dpcr_pkg::SEL_PREFIX;
        fire      = !out_stall;
        if (fire) begin
          if (status.prefix_last) begin
            cmd.idx_op = dpcr_pkg::IDX_CLEAR;
            state_next = dpcr_pkg::ST_FIXED;
          end else begin
            cmd.idx_op = dpcr_pkg::IDX_INC;
          end
        end
      end
      dpcr_pkg::ST_FIXED: begin
        out_valid = 1'b1;
        cmd.sel   = dpcr_pkg::SEL_FIXED;
        fire      = !out_stall;
        if (fire) begin
          if (status.fixed_last) begin
            cmd.idx_op = dpcr_pkg::IDX_LEAD;
            state_next = dpcr_pkg::ST_DIGIT;
          end else begin
            cmd.idx_op = dpcr_pkg::IDX_INC;
          end
        end
      end
      dpcr_pkg::ST_DIGIT: begin
        out_valid = 1'b1;
        cmd.sel   = dpcr_pkg::SEL_DIGIT;
        fire      = !out_stall;
        if (fire) begin
          if (status.idx_zero) begin
            state_next = dpcr_pkg::ST_NL;
          end else begin
            cmd.idx_op = dpcr_pkg::IDX_DEC;
          end
        end
      end
      dpcr_pkg::ST_NL: begin
        out_valid = 1'b1;
        cmd.sel   = dpcr_pkg::SEL_NL;
        fire      = !out_stall;
        if (fire) begin
          state_next = dpcr_pkg::ST_CR;
        end
      end
      dpcr_pkg::ST_CR: begin
        out_valid      = 1'b1;
        end_of_message = 1'b1;
        cmd.sel        = dpcr_pkg::SEL_CR;
        fire           = !out_stall;
        if (fire) begin
          state_next = dpcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dpcr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/dpcr_datapath.sv]
// ----------------------------------------------------------------------------
// dpcr_datapath: debounce state, press counter and decimal formatter
// Bit-serial shift-and-add-3 conversion, byte select for the message.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_datapath #(
  parameter int MAX_PREFIX_CHARS = 8,
  parameter int COUNT_BITS       = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dpcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data,
  input  wire logic                           pin_level,
  input  wire dpcr_pkg::cmd_t                 cmd,
  output dpcr_pkg::status_t                   status,
  output logic [7:0]                          text_byte
);

  localparam int DIGITS = (COUNT_BITS * 30103) / 100000 + 1;
  localparam int DIG_W  = $clog2(DIGITS);
  localparam int IDX_W  = (DIG_W > 3) ? DIG_W : 3;
  localparam int BIT_W  = $clog2(COUNT_BITS);
  localparam logic [3:0]       MAX_LEN  = 4'(MAX_PREFIX_CHARS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COUNT_BITS - 1);

  logic [63:0]             prefix_chars;
  logic [3:0]              prefix_length;
  logic [15:0]             debounce_ms;
  logic                    stable_pressed;
  logic [15:0]             elapsed_ticks;
  logic [COUNT_BITS-1:0]   press_count;
  logic [COUNT_BITS-1:0]   sh;
  logic [DIGITS*4-1:0]     bcd;
  logic [BIT_W-1:0]        bit_cnt;
  logic [IDX_W-1:0]        idx;

  logic                    pressed;
  logic [15:0]             elapsed_inc;
  logic                    change;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [DIGITS*4-1:0]     bcd_adj;
  logic [IDX_W-1:0]        lead;
  logic [3:0]              len_eff;
  logic [3:0]              cur_digit;

  assign pressed     = !pin_level;
  assign elapsed_inc = (elapsed_ticks == dpcr_pkg::ELAPSED_MAX) ? elapsed_ticks
                                                                 : elapsed_ticks + 16'd1;
  assign change      = (pressed != stable_pressed) && (elapsed_inc >= debounce_ms);
  assign count_inc   = press_count + COUNT_BITS'(1);
  assign len_eff     = (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3 : bcd[d*4 +: 4];
    end
  end

  always_comb begin
    lead = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign cur_digit = bcd[idx[DIG_W-1:0]*4 +: 4];

  always_comb begin
    case (cmd.sel)
      dpcr_pkg::SEL_PREFIX: text_byte = prefix_chars[idx[2:0]*8 +: 8];
      dpcr_pkg::SEL_FIXED:  text_byte = dpcr_pkg::fixed_char(idx[2:0]);
      dpcr_pkg::SEL_DIGIT:  text_byte = dpcr_pkg::CHAR_ZERO | {4'd0, cur_digit};
      dpcr_pkg::SEL_NL:     text_byte = dpcr_pkg::CHAR_LF;
      dpcr_pkg::SEL_CR:     text_byte = dpcr_pkg::CHAR_CR;
      default:              text_byte = dpcr_pkg::CHAR_CR;
    endcase
  end

  assign status.press_evt   = cmd.take_tick && change && pressed;
  assign status.conv_last   = (bit_cnt == BIT_LAST);
  assign status.len_zero    = (len_eff == 4'd0);
  assign status.prefix_last = ({1'b0, idx[2:0]} == (len_eff - 4'd1));
  assign status.fixed_last  = (idx[2:0] == dpcr_pkg::FIXED_LAST);
  assign status.idx_zero    = (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_chars   <= '0;
      prefix_length  <= '0;
      debounce_ms    <= dpcr_pkg::DEBOUNCE_RESET;
      stable_pressed <= 1'b0;
      elapsed_ticks  <= '0;
      press_count    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          dpcr_pkg::REG_PREFIX_CHARS:  prefix_chars  <= cfg_data;
          dpcr_pkg::REG_PREFIX_LENGTH: prefix_length <= cfg_data[3:0];
          dpcr_pkg::REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.take_tick) begin
        if (change) begin
          stable_pressed <= pressed;
          elapsed_ticks  <= '0;
          if (pressed) begin
            press_count <= count_inc;
          end
        end else begin
          elapsed_ticks <= elapsed_inc;
        end
      end
    end
  end

  // converter and byte index
  always_ff @(posedge clk) begin
    if (status.press_evt) begin
      sh      <= count_inc;
      bcd     <= '0;
      bit_cnt <= '0;
    end else if (cmd.shift) begin
      sh      <= sh << 1;
      bcd     <= {bcd_adj[DIGITS*4-2:0], sh[COUNT_BITS-1]};
      bit_cnt <= bit_cnt + BIT_W'(1);
    end
    case (cmd.idx_op)
      dpcr_pkg::IDX_CLEAR: idx <= '0;
      dpcr_pkg::IDX_INC:   idx <= idx + IDX_W'(1);
      dpcr_pkg::IDX_DEC:   idx <= idx - IDX_W'(1);
      dpcr_pkg::IDX_LEAD:  idx <= lead;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/debounced_press_counter_reporter_top.sv]
// A tick with no accepted press leaves the block idle; the next tick is taken right after.
// An accepted press converts the count bit-serially (BCD shift over COUNT_BITS bits),
// then sends min(prefix_length, MAX_PREFIX_CHARS) + 5 + digits + 2 bytes,
// one per cycle when not stalled.
// Ticks are stalled from the cycle after the press tick until the final byte is taken.
// Synchronous reset clears debounce state and count, prefix empty, debounce 30.
// ----------------------------------------------------------------------------
// debounced_press_counter_reporter_top: debounced button press reporter
// Debounces a sampled button, counts presses and sends a text report.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_press_counter_reporter_top #(
  parameter int MAX_PREFIX_CHARS = 8,
  parameter int COUNT_BITS       = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dpcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           pin_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          text_byte,
  output logic                                end_of_message
);

  dpcr_pkg::cmd_t    cmd;
  dpcr_pkg::status_t status;

  dpcr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .end_of_message (end_of_message),
    .cmd            (cmd),
    .status         (status)
  );

  dpcr_datapath #(
    .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS),
    .COUNT_BITS       (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pin_level (pin_level),
    .cmd       (cmd),
    .status    (status),
    .text_byte (text_byte)
  );

  a_no_tick_while_sending: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("tick taken while a message is being sent");

  a_last_is_cr: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_message |-> text_byte == dpcr_pkg::CHAR_CR)
    else $error("end of message on a byte other than CR");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && end_of_message |=> !in_stall && !out_valid)
    else $error("not idle after final byte");

endmodule

`default_nettype wire
